[src/bmhq_pkg.sv]
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int ID_W     = 8;

  localparam int IN_DATA_W  = ((KEY_W + ID_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + ID_W + CNT_W + 7) / 8) * 8;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  ident;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         ins_start;
    logic         up_rd;
    logic         up_move;
    logic         ex_rd;
    logic         ex_load;
    logic         dn_rd;
    logic         dn_move;
    logic         wr_hold;
    logic         out_load;
    status_code_t code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic up_more;
    logic up_swap;
    logic dn_more;
    logic dn_swap;
  } stat_t;

endpackage

`default_nettype wire

[src/bmhq_ctrl.sv]
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_kind,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire stat_t st,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_RESP
  } state_t;

  state_t       state_r, state_nxt;
  status_code_t code_r, code_nxt;
  logic         out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    cmd           = '0;
    cmd.code      = code_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            if (st.full) begin
              code_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.ins_start = 1'b1;
              code_nxt      = ST_INSERTED;
              state_nxt     = S_UP_CHK;
            end
          end else begin
            if (st.empty) begin
              code_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.ex_rd = 1'b1;
              code_nxt  = ST_REMOVED;
              state_nxt = S_EX_LD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (st.up_more) begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_UP_CMP: begin
        if (st.up_swap) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_EX_LD: begin
        cmd.ex_load = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.dn_more) begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DN_CMP;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_DN_CMP: begin
        if (st.dn_swap) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_CHK;
        end else begin
          cmd.wr_hold = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        // The result register takes a new request once its old one has left.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_INSERTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/bmhq_dp.sv]
`default_nettype none

module bmhq_dp import bmhq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [ID_W-1:0]  in_ident,
  output stat_t                 st,
  output status_code_t          res_status,
  output logic [KEY_W-1:0]      res_key,
  output logic [ID_W-1:0]       res_ident,
  output logic [CNT_W-1:0]      res_occupancy
);

  entry_t mem [CAPACITY];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  entry_t           e_r, e_nxt;
  entry_t           root_r, root_nxt;
  entry_t           rd0_r, rd1_r;

  status_code_t     ost_r;
  logic [KEY_W-1:0] okey_r;
  logic [ID_W-1:0]  oid_r;
  logic [CNT_W-1:0] occ_r;

  logic [CNT_W-1:0]  parent_pos;
  logic [CNT_W:0]    child_pos;
  logic [CNT_W:0]    cnt_ext;
  logic              right_ok;
  entry_t            chosen;
  logic [CNT_W:0]    chosen_pos;
  logic              rd_en;
  logic [ADDR_W-1:0] ra0, ra1, wa;
  logic              we;
  entry_t            wd;
  logic [CNT_W:0]    child_m1;

  // One-based heap position to storage address.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] p);
    logic [CNT_W-1:0] a;
    a = p - CNT_W'(1);
    return a[ADDR_W-1:0];
  endfunction

  assign parent_pos = pos_r >> 1;
  assign child_pos  = {pos_r, 1'b0};
  assign cnt_ext    = {1'b0, cnt_r};
  assign child_m1   = child_pos - (CNT_W+1)'(1);

  // The right child wins only when it exists and is strictly smaller.
  assign right_ok   = (child_pos < cnt_ext) && (rd1_r.key < rd0_r.key);
  assign chosen     = right_ok ? rd1_r : rd0_r;
  assign chosen_pos = right_ok ? child_pos + (CNT_W+1)'(1) : child_pos;

  assign st.full    = (cnt_r == CNT_W'(CAPACITY));
  assign st.empty   = (cnt_r == '0);
  assign st.up_more = (pos_r > CNT_W'(1));
  assign st.up_swap = (e_r.key < rd0_r.key);
  assign st.dn_more = (child_pos <= cnt_ext);
  assign st.dn_swap = !(e_r.key < chosen.key);

  always_comb begin
    rd_en = cmd.up_rd | cmd.ex_rd | cmd.dn_rd;
    ra0   = addr_of(parent_pos);
    ra1   = addr_of(cnt_r);
    if (cmd.ex_rd) begin
      ra0 = '0;
    end else if (cmd.dn_rd) begin
      ra0 = child_m1[ADDR_W-1:0];
      ra1 = child_pos[ADDR_W-1:0];
    end
    we = cmd.up_move | cmd.dn_move | cmd.wr_hold;
    wa = addr_of(pos_r);
    wd = e_r;
    if (cmd.up_move) begin
      wd = rd0_r;
    end else if (cmd.dn_move) begin
      wd = chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    e_nxt    = e_r;
    root_nxt = root_r;
    if (cmd.ins_start) begin
      e_nxt   = '{key: in_key, ident: in_ident};
      cnt_nxt = cnt_r + CNT_W'(1);
      pos_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.ex_load) begin
      root_nxt = rd0_r;
      e_nxt    = rd1_r;
      cnt_nxt  = cnt_r - CNT_W'(1);
      pos_nxt  = CNT_W'(1);
    end
    if (cmd.up_move) begin
      pos_nxt = parent_pos;
    end
    if (cmd.dn_move) begin
      pos_nxt = chosen_pos[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    pos_r  <= pos_nxt;
    e_r    <= e_nxt;
    root_r <= root_nxt;
    if (cmd.out_load) begin
      ost_r <= cmd.code;
      occ_r <= cnt_r;
      if (cmd.code == ST_REMOVED) begin
        okey_r <= root_r.key;
        oid_r  <= root_r.ident;
      end else begin
        okey_r <= '0;
        oid_r  <= '0;
      end
    end
  end

  assign res_status    = ost_r;
  assign res_key       = okey_r;
  assign res_ident     = oid_r;
  assign res_occupancy = occ_r;

endmodule

`default_nettype wire

[src/binary_min_heap_queue.sv]
`default_nettype none

// Channel  Direction  tuser           tdata
// in_      request    kind            entry_key, entry_ident
// out_     result     status          out_key, out_ident, occupancy
//
// An insert climbs the heap level by level and an extract descends it;
// each level needs a registered memory read and a compare before the next
// address is known. Full and empty requests skip the walk and go straight
// to the result. Reset empties the heap at once.
// A waiting result holds its register; the next request is still taken.

module binary_min_heap_queue import bmhq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // entry_key, entry_ident
  input  wire logic                  in_tuser,   // kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_key, out_ident, occupancy, zero pad
  output logic [1:0]                 out_tuser   // status
);

  cmd_t             cmd;
  stat_t            st;
  status_code_t     res_status;
  logic [KEY_W-1:0] res_key;
  logic [ID_W-1:0]  res_ident;
  logic [CNT_W-1:0] res_occupancy;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bmhq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_key        (in_tdata[KEY_W-1:0]),
    .in_ident      (in_tdata[KEY_W+ID_W-1:KEY_W]),
    .st            (st),
    .res_status    (res_status),
    .res_key       (res_key),
    .res_ident     (res_ident),
    .res_occupancy (res_occupancy)
  );

  assign out_tuser = res_status;
  assign out_tdata = OUT_DATA_W'({res_occupancy, res_ident, res_key});

endmodule

`default_nettype wire
